>>> src/hse_pkg.sv
// ----------------------------------------------------------------------------
// hse_pkg
// Shared types and codes for the heap sort engine: datapath command codes,
// the command and status bundles between controller and datapath, and the
// register map of the configuration port.
// ----------------------------------------------------------------------------
package hse_pkg;

    // Datapath operation codes
    localparam logic [3:0] DP_NOP       = 4'd0;
    localparam logic [3:0] DP_LOAD      = 4'd1;
    localparam logic [3:0] DP_UP        = 4'd2;
    localparam logic [3:0] DP_PLACE     = 4'd3;
    localparam logic [3:0] DP_SORT_INIT = 4'd4;
    localparam logic [3:0] DP_SWAP_RD   = 4'd5;
    localparam logic [3:0] DP_SWAP_WR   = 4'd6;
    localparam logic [3:0] DP_DN        = 4'd7;
    localparam logic [3:0] DP_READ      = 4'd8;
    localparam logic [3:0] DP_EMIT_KEY  = 4'd9;
    localparam logic [3:0] DP_EMIT_OVF  = 4'd10;

    // Configuration port
    localparam int unsigned APB_ADDR_W     = 3;
    localparam logic        REG_SORT_ORDER = 1'b0;   // register index, paddr[2]

    // Input op codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic [3:0] op;
        logic       fresh;   // load starts a new batch
        logic       order;   // 0: max-heap, 1: min-heap
    } hse_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic count_zero;
        logic up_ahead;
        logic up_at_top;
        logic end_gt1;
        logic swap_leaf;
        logic dn_go;
        logic dn_leaf;
        logic rd_avail;
        logic rd_last;
    } hse_sts_t;

endpackage

>>> src/hse_datapath.sv
// ----------------------------------------------------------------------------
// hse_datapath
// Heap store (one write port, two registered read ports), the sift
// registers, element count, read pointer and the result register.
// ----------------------------------------------------------------------------
module hse_datapath #(
    parameter int unsigned DEPTH    = 1024,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  hse_pkg::hse_cmd_t   cmd,
    output hse_pkg::hse_sts_t   sts,
    input  logic signed [31:0]  key,
    output logic signed [31:0]  sorted_key,
    output logic                end_of_data,
    output logic                overflow
);

    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned IW    = CW + 1;
    localparam int unsigned EXT_W = (KEY_BITS > 32) ? KEY_BITS : 32;

    typedef logic [KEY_BITS-1:0] word_t;

    // heap store
    word_t mem [DEPTH];
    word_t rd_a_reg;
    word_t rd_b_reg;

    // sift state
    word_t         v_reg, v_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [CW-1:0] end_reg, end_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rptr_reg, rptr_next;

    // result register
    logic [31:0] sorted_key_reg, sorted_key_next;
    logic        end_of_data_reg, end_of_data_next;
    logic        overflow_reg, overflow_next;
    logic        out_load;

    // memory controls
    logic          we;
    logic [AW-1:0] wa;
    word_t         wd;
    logic          re_a, re_b;
    logic [AW-1:0] ra, rb;

    // key width conversion
    logic [EXT_W-1:0] key_ext;
    word_t            key_word;
    logic [EXT_W-1:0] rd_ext;

    // sift helpers
    logic [AW-1:0] up_idx, upup_idx;
    logic [CW-1:0] base;
    logic [IW-1:0] lc, rc, best_idx, nlc, nrc;
    logic          rc_ok, pick_r;
    word_t         best_val;
    logic          up_ahead, dn_go;

    // true when x belongs nearer the root than y
    function automatic logic ahead(input word_t x, input word_t y, input logic order);
        logic signed [KEY_BITS-1:0] sx;
        logic signed [KEY_BITS-1:0] sy;
        begin
            sx = x;
            sy = y;
            ahead = order ? (sx < sy) : (sx > sy);
        end
    endfunction

    assign key_ext  = EXT_W'(key);
    assign key_word = key_ext[KEY_BITS-1:0];
    assign rd_ext   = EXT_W'(rd_a_reg);

    // parent indices for sift-up
    assign up_idx   = (pos_reg - AW'(1)) >> 1;
    assign upup_idx = (up_idx - AW'(1)) >> 1;
    assign base     = cmd.fresh ? '0 : count_reg;
    assign up_ahead = ahead(v_reg, rd_a_reg, cmd.order);

    // child selection for sift-down
    assign lc       = (IW'(pos_reg) << 1) + IW'(1);
    assign rc       = lc + IW'(1);
    assign rc_ok    = rc < IW'(end_reg);
    assign pick_r   = rc_ok && ahead(rd_b_reg, rd_a_reg, cmd.order);
    assign best_val = pick_r ? rd_b_reg : rd_a_reg;
    assign best_idx = pick_r ? rc : lc;
    assign dn_go    = ahead(best_val, v_reg, cmd.order);
    assign nlc      = {best_idx[CW-1:0], 1'b1};
    assign nrc      = nlc + IW'(1);

    // status to controller
    always_comb
    begin
        sts.full       = count_reg == CW'(DEPTH);
        sts.count_zero = count_reg == '0;
        sts.up_ahead   = up_ahead;
        sts.up_at_top  = up_idx == '0;
        sts.end_gt1    = end_reg > CW'(1);
        sts.swap_leaf  = end_reg <= CW'(2);
        sts.dn_go      = dn_go;
        sts.dn_leaf    = nlc >= IW'(end_reg);
        sts.rd_avail   = rptr_reg < count_reg;
        sts.rd_last    = (rptr_reg + CW'(1)) >= count_reg;
    end

    // command decode
    always_comb
    begin
        v_next           = v_reg;
        pos_next         = pos_reg;
        end_next         = end_reg;
        count_next       = count_reg;
        rptr_next        = rptr_reg;
        sorted_key_next  = sorted_key_reg;
        end_of_data_next = end_of_data_reg;
        overflow_next    = overflow_reg;
        out_load         = 1'b0;
        we               = 1'b0;
        wa               = pos_reg;
        wd               = v_reg;
        re_a             = 1'b0;
        re_b             = 1'b0;
        ra               = '0;
        rb               = '0;
        case (cmd.op)
            hse_pkg::DP_LOAD:
            begin
                v_next     = key_word;
                pos_next   = base[AW-1:0];
                count_next = base + CW'(1);
                rptr_next  = '0;
                re_a       = 1'b1;
                ra         = (base[AW-1:0] - AW'(1)) >> 1;
            end
            hse_pkg::DP_UP:
            begin
                we = 1'b1;
                if (up_ahead)
                begin
                    wd       = rd_a_reg;
                    pos_next = up_idx;
                    re_a     = 1'b1;
                    ra       = upup_idx;
                end
            end
            hse_pkg::DP_PLACE:
            begin
                we = 1'b1;
            end
            hse_pkg::DP_SORT_INIT:
            begin
                end_next  = count_reg;
                rptr_next = '0;
            end
            hse_pkg::DP_SWAP_RD:
            begin
                re_a = 1'b1;
                re_b = 1'b1;
                ra   = '0;
                rb   = AW'(end_reg - CW'(1));
            end
            hse_pkg::DP_SWAP_WR:
            begin
                we       = 1'b1;
                wa       = AW'(end_reg - CW'(1));
                wd       = rd_a_reg;
                v_next   = rd_b_reg;
                pos_next = '0;
                end_next = end_reg - CW'(1);
                re_a     = 1'b1;
                re_b     = 1'b1;
                ra       = AW'(1);
                rb       = AW'(2);
            end
            hse_pkg::DP_DN:
            begin
                we = 1'b1;
                if (dn_go)
                begin
                    wd       = best_val;
                    pos_next = best_idx[AW-1:0];
                    re_a     = 1'b1;
                    re_b     = 1'b1;
                    ra       = nlc[AW-1:0];
                    rb       = nrc[AW-1:0];
                end
            end
            hse_pkg::DP_READ:
            begin
                re_a = 1'b1;
                ra   = rptr_reg[AW-1:0];
            end
            hse_pkg::DP_EMIT_KEY:
            begin
                out_load         = 1'b1;
                sorted_key_next  = rd_ext[31:0];
                end_of_data_next = sts.rd_last;
                overflow_next    = 1'b0;
                if (sts.rd_last)
                begin
                    count_next = '0;
                    rptr_next  = '0;
                end
                else
                begin
                    rptr_next = rptr_reg + CW'(1);
                end
            end
            hse_pkg::DP_EMIT_OVF:
            begin
                out_load         = 1'b1;
                sorted_key_next  = '0;
                end_of_data_next = 1'b0;
                overflow_next    = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // heap store ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re_a)
        begin
            rd_a_reg <= mem[ra];
        end
        if (re_b)
        begin
            rd_b_reg <= mem[rb];
        end
    end

    // counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_reg   <= '0;
            count_reg <= '0;
            rptr_reg  <= '0;
        end
        else
        begin
            end_reg   <= end_next;
            count_reg <= count_next;
            rptr_reg  <= rptr_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        pos_reg <= pos_next;
        if (out_load)
        begin
            sorted_key_reg  <= sorted_key_next;
            end_of_data_reg <= end_of_data_next;
            overflow_reg    <= overflow_next;
        end
    end

    assign sorted_key  = sorted_key_reg;
    assign end_of_data = end_of_data_reg;
    assign overflow    = overflow_reg;

    // read pointer never passes the element count
    a_rptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rptr_reg <= count_reg)
        else $error("read pointer beyond element count");

    // heap size during sort never exceeds element count
    a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        end_reg <= count_reg || count_reg == '0)
        else $error("sort size beyond element count");

    // sift-down only runs on a node that has a child
    a_dn_child: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == hse_pkg::DP_DN |-> lc < IW'(end_reg))
        else $error("sift-down step on a leaf");

endmodule

>>> src/hse_ctrl.sv
// ----------------------------------------------------------------------------
// hse_ctrl
// Sequencer for load, sort and read phases, the configuration register and
// the output valid flag.
// ----------------------------------------------------------------------------
module hse_ctrl (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 op,
    input  logic                                 last_key,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [hse_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready,
    output hse_pkg::hse_cmd_t                    cmd,
    input  hse_pkg::hse_sts_t                    sts
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_UP        = 4'd1;
    localparam logic [3:0] S_PLACE_UP  = 4'd2;
    localparam logic [3:0] S_OVF       = 4'd3;
    localparam logic [3:0] S_SORT_INIT = 4'd4;
    localparam logic [3:0] S_SORT_CHK  = 4'd5;
    localparam logic [3:0] S_SWAP_WR   = 4'd6;
    localparam logic [3:0] S_DN        = 4'd7;
    localparam logic [3:0] S_PLACE_DN  = 4'd8;
    localparam logic [3:0] S_RD_EMIT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       last_reg, last_next;
    logic       sorted_reg, sorted_next;
    logic       out_valid_reg, out_valid_next;
    logic       order_reg;
    logic       accept;
    logic       slot_free;
    logic       emit;
    logic       cfg_wr;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == hse_pkg::REG_SORT_ORDER);
    assign prdata = (paddr[2] == hse_pkg::REG_SORT_ORDER) ? {31'b0, order_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            order_reg <= pwdata[0];
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign accept    = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        last_next   = last_reg;
        sorted_next = sorted_reg;
        emit        = 1'b0;
        cmd.op      = hse_pkg::DP_NOP;
        cmd.fresh   = 1'b0;
        cmd.order   = order_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == hse_pkg::OP_LOAD)
                    begin
                        last_next   = last_key;
                        sorted_next = 1'b0;
                        if (!sorted_reg && sts.full)
                        begin
                            state_next = S_OVF;
                        end
                        else
                        begin
                            cmd.op    = hse_pkg::DP_LOAD;
                            cmd.fresh = sorted_reg;
                            state_next = (sorted_reg || sts.count_zero) ? S_PLACE_UP : S_UP;
                        end
                    end
                    else if (sorted_reg && sts.rd_avail)
                    begin
                        cmd.op     = hse_pkg::DP_READ;
                        state_next = S_RD_EMIT;
                    end
                end
            end
            S_UP:
            begin
                cmd.op = hse_pkg::DP_UP;
                if (!sts.up_ahead)
                begin
                    state_next = last_reg ? S_SORT_INIT : S_IDLE;
                end
                else if (sts.up_at_top)
                begin
                    state_next = S_PLACE_UP;
                end
            end
            S_PLACE_UP:
            begin
                cmd.op     = hse_pkg::DP_PLACE;
                state_next = last_reg ? S_SORT_INIT : S_IDLE;
            end
            S_OVF:
            begin
                if (slot_free)
                begin
                    cmd.op     = hse_pkg::DP_EMIT_OVF;
                    emit       = 1'b1;
                    state_next = last_reg ? S_SORT_INIT : S_IDLE;
                end
            end
            S_SORT_INIT:
            begin
                cmd.op     = hse_pkg::DP_SORT_INIT;
                state_next = S_SORT_CHK;
            end
            S_SORT_CHK:
            begin
                if (sts.end_gt1)
                begin
                    cmd.op     = hse_pkg::DP_SWAP_RD;
                    state_next = S_SWAP_WR;
                end
                else
                begin
                    sorted_next = !sts.count_zero;
                    state_next  = S_IDLE;
                end
            end
            S_SWAP_WR:
            begin
                cmd.op     = hse_pkg::DP_SWAP_WR;
                state_next = sts.swap_leaf ? S_PLACE_DN : S_DN;
            end
            S_DN:
            begin
                cmd.op = hse_pkg::DP_DN;
                if (!sts.dn_go)
                begin
                    state_next = S_SORT_CHK;
                end
                else if (sts.dn_leaf)
                begin
                    state_next = S_PLACE_DN;
                end
            end
            S_PLACE_DN:
            begin
                cmd.op     = hse_pkg::DP_PLACE;
                state_next = S_SORT_CHK;
            end
            S_RD_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.op     = hse_pkg::DP_EMIT_KEY;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (sts.rd_last)
                    begin
                        sorted_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid: set on emit, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            sorted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_reg      <= last_next;
            sorted_reg    <= sorted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // sorted data implies keys are held
    a_sorted_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        sorted_reg |-> !sts.count_zero)
        else $error("sorted flag set with empty store");

    // a read in flight always has a key to return
    a_read_avail: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD_EMIT |-> sts.rd_avail)
        else $error("read issued past element count");

    // final key read empties the batch
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD_EMIT && slot_free && sts.rd_last) |=> !sorted_reg && sts.count_zero)
        else $error("batch not cleared after final key");

    // load into a full store reports overflow
    a_full_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == hse_pkg::OP_LOAD && !sorted_reg && sts.full) |=> state_reg == S_OVF)
        else $error("dropped load not reported");

endmodule

>>> src/heap_sort_engine_unit.sv
// ----------------------------------------------------------------------------
// heap_sort_engine_unit
// Binary heap sort of signed Q16.16 keys with a request/result stream and an
// APB-style configuration port.
// ----------------------------------------------------------------------------
// Keys are loaded one request at a time (op 0) and sifted up into an on-chip
// heap store as they arrive; the load that carries last_key starts an
// in-place sort, after which each read request (op 1) returns the next key,
// ascending when sort_order is 0 and descending when it is 1, with
// end_of_data on the final key. A load after a finished sort starts a new
// batch. A load into a full store returns one result with overflow set. The
// heap store has one write port and two read ports with registered data, and
// the sifts move through the heap level by level: a load sifts the new key
// up, the sort after the last key swaps each key out and sifts down, and a
// read fetches the key and then emits it. The store is not cleared after
// reset and needs no clearing pass.
// ----------------------------------------------------------------------------
module heap_sort_engine_unit #(
    parameter int unsigned DEPTH    = 1024,
    parameter int unsigned KEY_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic signed [31:0]               key,
    input  logic                             last_key,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [31:0]               sorted_key,
    output logic                             end_of_data,
    output logic                             overflow,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hse_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    hse_pkg::hse_cmd_t cmd;
    hse_pkg::hse_sts_t sts;

    // sequencer
    hse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .last_key  (last_key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // heap store and datapath
    hse_datapath #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .key         (key),
        .sorted_key  (sorted_key),
        .end_of_data (end_of_data),
        .overflow    (overflow)
    );

endmodule
